### rtl/assert_macros.svh
// Assertion macros used by the dispatcher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define SPD_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispatcher check failed");
// Next-cycle implication.
`define SPD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispatcher check failed");
`else
`define SPD_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define SPD_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

### rtl/spd_pkg.sv
// Shared constants, types and helpers of the strict priority task dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package spd_pkg;

    localparam int NUM_PRIORITIES_DEF = 3;
    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int TASK_IDS_DEF       = 256;

    localparam int ID_W   = 8;
    localparam int MODE_W = 2;
    localparam int PRIO_W = 2;
    localparam int DISC_W = 6;

    localparam logic [MODE_W-1:0] MODE_POST     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL   = 2'd2;

    localparam logic [DISC_W-1:0] DISC_MAX = '1;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clr_step;
        logic exec;
        logic search;
        logic pop;
        logic judge;
        logic finish;
    } spd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic want_dispatch;
        logic any_queued;
        logic canceled;
        logic out_free;
    } spd_sts_t;

    // id modulo n by reciprocal multiplication, recip = ceil(2^16 / n);
    // exact for every 8-bit id and 2 <= n <= 4096
    function automatic logic [11:0] id_mod(input logic [ID_W-1:0] id,
                                           input logic [15:0] recip,
                                           input logic [12:0] n);
        logic [23:0] prod;
        logic [20:0] qn;
        prod = {16'd0, id} * {8'd0, recip};
        qn   = {13'd0, prod[23:16]} * {8'd0, n};
        return {4'd0, id - qn[ID_W-1:0]};
    endfunction

endpackage
`default_nettype wire

### rtl/strict_priority_task_dispatcher.sv
// Top level of the strict priority task dispatcher.
//
//   channel   signals                                        direction
//   in        in_valid/in_ready, mode, task_id, priority_req  event in
//   out       out_valid/out_ready, start_valid, start_task_id,
//             busy_res, dropped_full, bad_completion,
//             discarded_count                                 result out
//
// One event at a time. Without a dispatch, an accepted event passes S_EXEC and S_DONE,
// where out_valid and in_ready rise as it leaves; a dispatch adds S_SEARCH, S_ENTRY
// and S_MARK per head popped (entry read, cancel mark read, decision), plus a final
// S_SEARCH when the search ends on empty queues. After reset the cancel marks are swept
// clear with in_ready low. A result waiting on out_ready does not block the next event
// from being taken; the event after that waits until the result register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module strict_priority_task_dispatcher #(
    parameter int NUM_PRIORITIES = spd_pkg::NUM_PRIORITIES_DEF,
    parameter int QUEUE_DEPTH    = spd_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_IDS       = spd_pkg::TASK_IDS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [spd_pkg::MODE_W-1:0]   mode,
    input  wire logic [spd_pkg::ID_W-1:0]     task_id,
    input  wire logic [spd_pkg::PRIO_W-1:0]   priority_req,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              start_valid,
    output logic [spd_pkg::ID_W-1:0]          start_task_id,
    output logic                              busy_res,
    output logic                              dropped_full,
    output logic                              bad_completion,
    output logic [spd_pkg::DISC_W-1:0]        discarded_count
);

    spd_pkg::spd_cmd_t cmd;
    spd_pkg::spd_sts_t sts;

    spd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spd_datapath #(
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .TASK_IDS       (TASK_IDS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .mode            (mode),
        .task_id         (task_id),
        .priority_req    (priority_req),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .start_valid     (start_valid),
        .start_task_id   (start_task_id),
        .busy_res        (busy_res),
        .dropped_full    (dropped_full),
        .bad_completion  (bad_completion),
        .discarded_count (discarded_count)
    );

    // a started task is running when the transaction is reported
    `SPD_ASSERT_IMPL(a_start_busy, clk, rst_n, out_valid && start_valid, busy_res)
    // a rejected completion neither dispatches nor discards
    `SPD_ASSERT_IMPL(a_bad_quiet, clk, rst_n, out_valid && bad_completion, !start_valid && discarded_count == '0)
    // the queues are only popped while an event is in flight
    `SPD_ASSERT_IMPL(a_pop_busy, clk, rst_n, cmd.pop || cmd.judge, !in_ready)

endmodule
`default_nettype wire

### rtl/spd_ctrl.sv
// Sequencing state machine of the dispatcher.
`timescale 1ns / 1ps
`default_nettype none
module spd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire spd_pkg::spd_sts_t sts,
    output spd_pkg::spd_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_ENTRY,
        S_MARK,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = !sts.clr_done;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.want_dispatch ? S_SEARCH : S_DONE;
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = sts.any_queued ? S_ENTRY : S_DONE;
            end
            S_ENTRY:
            begin
                cmd.pop    = 1'b1;
                state_next = S_MARK;
            end
            S_MARK:
            begin
                cmd.judge  = 1'b1;
                // canceled head: drop it and look again
                state_next = sts.canceled ? S_SEARCH : S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule
`default_nettype wire

### rtl/spd_datapath.sv
// Queues, cancel marks, running task and result register of the dispatcher.
`timescale 1ns / 1ps
`default_nettype none
module spd_datapath #(
    parameter int NUM_PRIORITIES = spd_pkg::NUM_PRIORITIES_DEF,
    parameter int QUEUE_DEPTH    = spd_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_IDS       = spd_pkg::TASK_IDS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire spd_pkg::spd_cmd_t            cmd,
    output spd_pkg::spd_sts_t                 sts,
    input  wire logic [spd_pkg::MODE_W-1:0]   mode,
    input  wire logic [spd_pkg::ID_W-1:0]     task_id,
    input  wire logic [spd_pkg::PRIO_W-1:0]   priority_req,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              start_valid,
    output logic [spd_pkg::ID_W-1:0]          start_task_id,
    output logic                              busy_res,
    output logic                              dropped_full,
    output logic                              bad_completion,
    output logic [spd_pkg::DISC_W-1:0]        discarded_count
);

    localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int ENTRIES = NUM_PRIORITIES * QUEUE_DEPTH;
    localparam int AW = $clog2(ENTRIES);
    localparam int MW = $clog2(TASK_IDS);
    localparam int IW = spd_pkg::ID_W;
    localparam int DW = spd_pkg::DISC_W;
    localparam int unsigned MOD_RECIP = (32'd65536 + TASK_IDS - 1) / TASK_IDS;

    // storage
    logic [IW-1:0] entry_mem [ENTRIES];
    logic          mark_mem  [TASK_IDS];

    // control state
    logic [CW-1:0] count_reg [NUM_PRIORITIES];
    logic [HW-1:0] head_reg  [NUM_PRIORITIES];
    logic          running_reg;
    logic [IW-1:0] run_id_reg;
    logic [MW:0]   clr_cnt_reg;
    logic          out_valid_reg;

    // per-event payload
    logic [spd_pkg::MODE_W-1:0] mode_reg;
    logic [IW-1:0]  id_reg;
    logic [PW-1:0]  prio_reg;
    logic [PW-1:0]  sel_reg;
    logic [IW-1:0]  entry_rdata_reg;
    logic           mark_rdata_reg;
    logic [DW-1:0]  disc_reg;
    logic           started_reg;
    logic           dropped_reg;
    logic           bad_reg;

    // result register
    logic           start_valid_reg;
    logic [IW-1:0]  start_id_reg;
    logic           busy_reg;
    logic           dropped_out_reg;
    logic           bad_out_reg;
    logic [DW-1:0]  disc_out_reg;

    logic [3:0]     prio_ext;
    logic [PW-1:0]  prio_sat;
    logic [PW-1:0]  found;
    logic           any_queued;
    logic [PW-1:0]  qidx;
    logic [CW-1:0]  cnt_q;
    logic [HW-1:0]  head_q;
    logic [SW-1:0]  tail_sum;
    logic [HW-1:0]  tail;
    logic           full;
    logic           match;
    logic           is_post;
    logic           is_complete;
    logic           is_cancel;
    logic           push;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;
    logic           mark_we;
    logic [MW-1:0]  mark_waddr;
    logic           mark_wdata;
    logic [MW-1:0]  id_midx;
    logic [MW-1:0]  entry_midx;

    // priorities above the top level saturate to it
    assign prio_ext = {2'b00, priority_req};
    assign prio_sat = (prio_ext >= 4'(NUM_PRIORITIES)) ? PW'(NUM_PRIORITIES - 1)
                                                       : PW'(prio_ext);

    always_comb
    begin
        any_queued = 1'b0;
        found      = '0;
        for (int p = 0; p < NUM_PRIORITIES; p++)
        begin
            if (count_reg[p] != '0)
            begin
                any_queued = 1'b1;
                found      = PW'(p);
            end
        end
    end

    always_comb
    begin
        priority if (cmd.exec)
        begin
            qidx = prio_reg;
        end
        else if (cmd.search)
        begin
            qidx = found;
        end
        else
        begin
            qidx = sel_reg;
        end
    end

    assign cnt_q    = count_reg[qidx];
    assign head_q   = head_reg[qidx];
    assign tail_sum = SW'(head_q) + SW'(cnt_q);
    assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : HW'(tail_sum);
    assign full     = (cnt_q == CW'(QUEUE_DEPTH));

    assign is_post     = (mode_reg == spd_pkg::MODE_POST);
    assign is_complete = (mode_reg == spd_pkg::MODE_COMPLETE);
    assign is_cancel   = (mode_reg == spd_pkg::MODE_CANCEL);
    assign match       = running_reg && (run_id_reg == id_reg);
    assign push        = cmd.exec && is_post && !full;

    assign wr_addr = AW'(32'(prio_reg) * QUEUE_DEPTH + 32'(tail));
    assign rd_addr = AW'(32'(found) * QUEUE_DEPTH + 32'(head_q));

    assign id_midx    = MW'(spd_pkg::id_mod(id_reg, 16'(MOD_RECIP), 13'(TASK_IDS)));
    assign entry_midx = MW'(spd_pkg::id_mod(entry_rdata_reg, 16'(MOD_RECIP), 13'(TASK_IDS)));

    always_comb
    begin
        mark_we    = 1'b0;
        mark_waddr = id_midx;
        mark_wdata = 1'b0;
        priority if (cmd.clr_step)
        begin
            mark_we    = 1'b1;
            mark_waddr = clr_cnt_reg[MW-1:0];
        end
        else if (push)
        begin
            mark_we = 1'b1;
        end
        else if (cmd.exec && is_cancel && !match)
        begin
            mark_we    = 1'b1;
            mark_wdata = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_addr] <= id_reg;
        end
        if (cmd.search)
        begin
            entry_rdata_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (cmd.pop)
        begin
            mark_rdata_reg <= mark_mem[entry_midx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PRIORITIES; p++)
            begin
                count_reg[p] <= '0;
                head_reg[p]  <= '0;
            end
            running_reg   <= 1'b0;
            run_id_reg    <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (push)
            begin
                count_reg[prio_reg] <= cnt_q + 1'b1;
            end
            if (cmd.exec && is_complete && match)
            begin
                running_reg <= 1'b0;
            end
            if (cmd.pop)
            begin
                count_reg[sel_reg] <= cnt_q - 1'b1;
                head_reg[sel_reg]  <= (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
            end
            if (cmd.judge && !mark_rdata_reg)
            begin
                running_reg <= 1'b1;
                run_id_reg  <= entry_rdata_reg;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            id_reg      <= task_id;
            prio_reg    <= prio_sat;
            disc_reg    <= '0;
            started_reg <= 1'b0;
            dropped_reg <= 1'b0;
            bad_reg     <= 1'b0;
        end
        if (cmd.exec)
        begin
            dropped_reg <= is_post && full;
            bad_reg     <= is_complete && !match;
        end
        if (cmd.search)
        begin
            sel_reg <= found;
        end
        if (cmd.judge)
        begin
            if (mark_rdata_reg)
            begin
                if (disc_reg != spd_pkg::DISC_MAX)
                begin
                    disc_reg <= disc_reg + 1'b1;
                end
            end
            else
            begin
                started_reg <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            start_valid_reg <= started_reg;
            start_id_reg    <= started_reg ? run_id_reg : '0;
            busy_reg        <= running_reg;
            dropped_out_reg <= dropped_reg;
            bad_out_reg     <= bad_reg;
            disc_out_reg    <= disc_reg;
        end
    end

    assign sts.clr_done      = (clr_cnt_reg == (MW + 1)'(TASK_IDS));
    assign sts.want_dispatch = (is_post && !running_reg) || (is_complete && match);
    assign sts.any_queued    = any_queued;
    assign sts.canceled      = mark_rdata_reg;
    assign sts.out_free      = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign start_valid     = start_valid_reg;
    assign start_task_id   = start_id_reg;
    assign busy_res        = busy_reg;
    assign dropped_full    = dropped_out_reg;
    assign bad_completion  = bad_out_reg;
    assign discarded_count = disc_out_reg;

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the strict priority task dispatcher.
`timescale 1ns / 1ps
module tb;

    localparam int NPRI         = spd_pkg::NUM_PRIORITIES_DEF;
    localparam int QDEPTH       = spd_pkg::QUEUE_DEPTH_DEF;
    localparam int NIDS         = spd_pkg::TASK_IDS_DEF;
    localparam int N_RANDOM     = 1550;
    localparam int DRAIN_CYCLES = 160;
    localparam logic [spd_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

    typedef struct packed {
        logic [spd_pkg::MODE_W-1:0] op;
        logic [spd_pkg::ID_W-1:0]   id;
        logic [spd_pkg::PRIO_W-1:0] pr;
    } dispatch_event_t;

    typedef struct packed {
        logic                       start;
        logic [spd_pkg::ID_W-1:0]   sid;
        logic                       busy;
        logic                       drop;
        logic                       bad;
        logic [spd_pkg::DISC_W-1:0] disc;
    } dispatch_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [spd_pkg::MODE_W-1:0]   mode = '0;
    logic [spd_pkg::ID_W-1:0]     task_id = '0;
    logic [spd_pkg::PRIO_W-1:0]   priority_req = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         start_valid;
    logic [spd_pkg::ID_W-1:0]     start_task_id;
    logic                         busy_res;
    logic                         dropped_full;
    logic                         bad_completion;
    logic [spd_pkg::DISC_W-1:0]   discarded_count;

    strict_priority_task_dispatcher dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .task_id         (task_id),
        .priority_req    (priority_req),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .start_valid     (start_valid),
        .start_task_id   (start_task_id),
        .busy_res        (busy_res),
        .dropped_full    (dropped_full),
        .bad_completion  (bad_completion),
        .discarded_count (discarded_count)
    );

    // Shadow of the scheduler state
    logic [spd_pkg::ID_W-1:0] q_ids [NPRI][QDEPTH];
    int unsigned              q_head [NPRI] = '{default: 0};
    int unsigned              q_cnt [NPRI] = '{default: 0};
    bit                       cancel_mark [NIDS];
    bit                       run_flag = 1'b0;
    logic [spd_pkg::ID_W-1:0] run_id = '0;

    dispatch_event_t  pending_events [$];
    dispatch_result_t expected_results [$];
    dispatch_event_t  next_ev;
    dispatch_result_t want;
    int               err_cnt = 0;
    bit               tx_steady = 1'b0;
    bit               rx_steady = 1'b0;
    int               burst_left = 0;
    int               gap_left = 0;
    int               rx_left = 0;

    // Pop heads from the highest non-empty level, skipping canceled ids
    function automatic void pick_next(inout dispatch_result_t r);
        int lvl;
        logic [spd_pkg::ID_W-1:0] hid;
        lvl = NPRI - 1;
        while (lvl >= 0) begin
            if (q_cnt[lvl] == 0) begin
                lvl--;
            end else begin
                hid = q_ids[lvl][q_head[lvl]];
                q_head[lvl] = (q_head[lvl] + 1) % QDEPTH;
                q_cnt[lvl]--;
                if (cancel_mark[int'(hid) % NIDS]) begin
                    if (r.disc != spd_pkg::DISC_MAX)
                        r.disc = r.disc + 1'b1;
                    lvl = NPRI - 1;
                end else begin
                    run_flag = 1'b1;
                    run_id = hid;
                    r.start = 1'b1;
                    r.sid = hid;
                    return;
                end
            end
        end
    endfunction

    function automatic dispatch_result_t apply_event(logic [spd_pkg::MODE_W-1:0] op,
                                                     logic [spd_pkg::ID_W-1:0] id,
                                                     logic [spd_pkg::PRIO_W-1:0] pr);
        dispatch_result_t r;
        int lvl;
        r = '0;
        lvl = (pr >= NPRI) ? NPRI - 1 : int'(pr);
        unique case (op)
            spd_pkg::MODE_POST: begin
                if (q_cnt[lvl] >= QDEPTH) begin
                    r.drop = 1'b1;
                end else begin
                    q_ids[lvl][(q_head[lvl] + q_cnt[lvl]) % QDEPTH] = id;
                    q_cnt[lvl]++;
                    cancel_mark[int'(id) % NIDS] = 1'b0;
                end
                if (!run_flag)
                    pick_next(r);
            end
            spd_pkg::MODE_COMPLETE: begin
                if (!run_flag || run_id != id) begin
                    r.bad = 1'b1;
                end else begin
                    run_flag = 1'b0;
                    pick_next(r);
                end
            end
            spd_pkg::MODE_CANCEL: begin
                if (!(run_flag && run_id == id))
                    cancel_mark[int'(id) % NIDS] = 1'b1;
            end
            default: ;
        endcase
        r.busy = run_flag;
        return r;
    endfunction

    task automatic queue_event(input logic [spd_pkg::MODE_W-1:0] op,
                               input logic [spd_pkg::ID_W-1:0] id,
                               input logic [spd_pkg::PRIO_W-1:0] pr);
        dispatch_event_t e;
        e.op = op;
        e.id = id;
        e.pr = pr;
        pending_events.insert(pending_events.size(), e);
    endtask

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sender: predicts on each accepted transaction, presents items in bursts unless tx_steady is set
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(),
                                        apply_event(mode, task_id, priority_req));
            if (!in_valid || in_ready) begin
                if (gap_left != 0 && !tx_steady) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_events.size() == 0) begin
                    in_valid <= 1'b0;
                end else begin
                    next_ev = pending_events[0];
                    pending_events.delete(0);
                    in_valid <= 1'b1;
                    mode <= next_ev.op;
                    task_id <= next_ev.id;
                    priority_req <= next_ev.pr;
                    if (burst_left <= 1) begin
                        burst_left <= int'($urandom_range(1, 12));
                        gap_left <= int'($urandom_range(1, 10));
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Receiver: alternating ready and stall runs of random length, or held ready while rx_steady
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_left <= 0;
        end else if (rx_steady) begin
            out_ready <= 1'b1;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else begin
            out_ready <= !out_ready;
            rx_left <= out_ready ? int'($urandom_range(0, 12)) : int'($urandom_range(0, 5));
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no expectation pending");
                err_cnt++;
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (start_valid !== want.start) begin
                    $error("start_valid expected %0d actual %0d", want.start, start_valid);
                    err_cnt++;
                end
                if (start_task_id !== want.sid) begin
                    $error("start_task_id expected %0d actual %0d", want.sid, start_task_id);
                    err_cnt++;
                end
                if (busy_res !== want.busy) begin
                    $error("busy_res expected %0d actual %0d", want.busy, busy_res);
                    err_cnt++;
                end
                if (dropped_full !== want.drop) begin
                    $error("dropped_full expected %0d actual %0d", want.drop, dropped_full);
                    err_cnt++;
                end
                if (bad_completion !== want.bad) begin
                    $error("bad_completion expected %0d actual %0d",
                           want.bad, bad_completion);
                    err_cnt++;
                end
                if (discarded_count !== want.disc) begin
                    $error("discarded_count expected %0d actual %0d",
                           want.disc, discarded_count);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        dispatch_event_t ev;
        int unsigned roll;
        int unsigned fill_left;
        logic [spd_pkg::PRIO_W-1:0] fill_lvl;
        fill_left = 0;
        fill_lvl = '0;

        // Directed: bad completions, unused mode, saturated priority, cancel
        // before post, cancel of the running task, duplicates, discards.
        queue_event(spd_pkg::MODE_COMPLETE, 8'h05, 2'd0);
        queue_event(MODE_NONE,              8'haa, 2'd3);
        queue_event(spd_pkg::MODE_CANCEL,   8'h00, 2'd0);
        queue_event(spd_pkg::MODE_POST,     8'hff, 2'd3);
        queue_event(spd_pkg::MODE_POST,     8'h00, 2'd0);
        queue_event(spd_pkg::MODE_POST,     8'h10, 2'd1);
        queue_event(spd_pkg::MODE_POST,     8'h10, 2'd1);
        queue_event(spd_pkg::MODE_POST,     8'h20, 2'd2);
        queue_event(spd_pkg::MODE_CANCEL,   8'hff, 2'd0);
        queue_event(spd_pkg::MODE_CANCEL,   8'h20, 2'd0);
        queue_event(spd_pkg::MODE_COMPLETE, 8'h11, 2'd0);
        queue_event(spd_pkg::MODE_COMPLETE, 8'hff, 2'd0);
        queue_event(spd_pkg::MODE_COMPLETE, 8'h10, 2'd0);
        queue_event(spd_pkg::MODE_POST,     8'h20, 2'd2);
        queue_event(spd_pkg::MODE_COMPLETE, 8'h10, 2'd0);
        queue_event(spd_pkg::MODE_CANCEL,   8'h00, 2'd0);
        queue_event(spd_pkg::MODE_COMPLETE, 8'h20, 2'd0);
        queue_event(spd_pkg::MODE_POST,     8'h00, 2'd0);
        queue_event(spd_pkg::MODE_COMPLETE, 8'h00, 2'd0);
        queue_event(MODE_NONE,              8'hff, 2'd3);

        // Random: one item at a time so completions can name the running id
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 250 == 0) begin
                tx_steady = ($urandom_range(0, 2) == 0);
                rx_steady = ($urandom_range(0, 2) == 0);
            end
            if (n % 300 == 150) begin
                while (pending_events.size() != 0 || in_valid ||
                       expected_results.size() != 0)
                    @(negedge clk);
            end
            while (pending_events.size() != 0 || in_valid)
                @(negedge clk);

            roll = $urandom_range(0, 99);
            ev.pr = 2'($urandom_range(0, 3));
            ev.id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 23));
            if (fill_left != 0) begin
                ev.op = spd_pkg::MODE_POST;
                ev.pr = fill_lvl;
                fill_left--;
            end else if (roll < 2) begin
                // flood one level to drive it full
                fill_left = $urandom_range(16, 20);
                fill_lvl = 2'($urandom_range(0, 3));
                ev.op = spd_pkg::MODE_POST;
                ev.pr = fill_lvl;
            end else if (roll < 6) begin
                ev.op = MODE_NONE;
            end else if (roll < 20) begin
                ev.op = spd_pkg::MODE_CANCEL;
                if (run_flag && roll < 9)
                    ev.id = run_id;
            end else if (run_flag && roll < 65) begin
                ev.op = spd_pkg::MODE_COMPLETE;
                if (roll >= 60)
                    ev.id = run_id ^ 8'(1 << $urandom_range(0, 7));
                else
                    ev.id = run_id;
            end else if (!run_flag && roll < 28) begin
                ev.op = spd_pkg::MODE_COMPLETE;
            end else begin
                ev.op = spd_pkg::MODE_POST;
            end
            queue_event(ev.op, ev.id, ev.pr);
        end

        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### strict_priority_task_dispatcher.f
+incdir+rtl
rtl/spd_pkg.sv
rtl/spd_ctrl.sv
rtl/spd_datapath.sv
rtl/strict_priority_task_dispatcher.sv
test/tb.sv
